// ----- hdl/tlj_pkg.sv -----
// Shared constants, widths and the width helper function of the text line justifier.
package tlj_pkg;

  localparam int MAX_LINE  = 64;
  localparam int MAX_WORDS = 32;
  localparam int LINE_AW   = $clog2(MAX_LINE);
  localparam int WORD_AW   = $clog2(MAX_WORDS);
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = WORD_AW + 1;

  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'd32;
  localparam logic [LEN_W-1:0]  WIDTH_RESET = 7'd50;

  // Width in use: zero reads as one, anything above the store depth as the depth.
  function automatic logic [LEN_W-1:0] eff_width(input logic [LEN_W-1:0] cfg);
    logic [LEN_W-1:0] w;
    w = cfg;
    if (w == '0) w = LEN_W'(1);
    if (w > LEN_W'(MAX_LINE)) w = LEN_W'(MAX_LINE);
    return w;
  endfunction

endpackage

// ----- hdl/tlj_ram.sv -----
// Generic simple dual-port synchronous RAM with a registered read port.
module tlj_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/tlj_div.sv -----
// Restoring divider for the gap spacing: one quotient bit per cycle.
module tlj_div
  import tlj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [LEN_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [LEN_W-1:0] quotient,
  output logic [CNT_W-1:0] remainder
);

  localparam int STEP_W = $clog2(LEN_W + 1);

  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  dv_r, dv_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [LEN_W-1:0]  sh;
  logic              ge;

  // One shift-and-subtract step per cycle.
  always_comb begin
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {acc_r[LEN_W-2:0], q_r[LEN_W-1]};
    ge       = sh >= LEN_W'(dv_r);
    if (start) begin
      acc_nxt  = '0;
      q_nxt    = dividend;
      dv_nxt   = divisor;
      cnt_nxt  = STEP_W'(LEN_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = ge ? sh - LEN_W'(dv_r) : sh;
      q_nxt   = {q_r[LEN_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    dv_r  <= dv_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = acc_r[CNT_W-1:0];

endmodule

// ----- hdl/text_line_justifier_unit.sv -----
// Top level of the text line justifier: request control, word buffering and line emission.
//
// Characters enter one request at a time. Each character is appended to the word
// in the partial-word RAM, up to the line width; a word end then copies the word
// into the line RAM, reading and then writing each letter, and records its length.
// Emitting a line takes a setup (with a run of the serial divider when the gaps
// must be spread), then reads each letter from the line RAM before sending it,
// sends each space directly and fetches the length of each further word, each
// output also waiting on out_stall; a line is always exactly the effective line
// width results long. While a line is being emitted no new character is taken.
// The three stores are RAMs with a registered read port; their reads add a step per letter.
module text_line_justifier_unit
  import tlj_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_word_end,
  input  logic              in_text_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_line_last,
  output logic              out_word_truncated,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_line_width
);

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_WORD, S_CPRD, S_CPWR, S_CPFIN,
    E_START, E_DIV, E_LEN, E_LENW, E_GAP, E_RD, E_CH, E_PAD
  } state_t;

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  logic [LEN_W-1:0]   width_r, width_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [LEN_W-1:0]   chars_r, chars_nxt;
  logic [LEN_W-1:0]   letters_r, letters_nxt;
  logic               trunc_r, trunc_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic               pcut_r, pcut_nxt;
  logic               held_r, held_nxt;
  logic               emitted_r, emitted_nxt;
  logic [CHAR_W-1:0]  c_r, c_nxt;
  logic               we_r, we_nxt;
  logic               te_r, te_nxt;
  logic [LINE_AW-1:0] ci_r, ci_nxt;
  logic [WORD_AW-1:0] wi_r, wi_nxt;
  logic [LINE_AW-1:0] src_r, src_nxt;
  logic [LINE_AW-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]   gap_r, gap_nxt;
  logic [LEN_W-1:0]   wrem_r, wrem_nxt;
  logic [LEN_W-1:0]   base_r, base_nxt;
  logic [CNT_W-1:0]   extra_r, extra_nxt;
  logic               flag_r, flag_nxt;
  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  och_r, och_nxt;
  logic               olast_r, olast_nxt;
  logic               otr_r, otr_nxt;

  // RAM ports.
  logic               pw_we, pw_re, ls_we, ls_re, wl_we, wl_re;
  logic [LINE_AW-1:0] pw_waddr, pw_raddr, ls_waddr, ls_raddr;
  logic [WORD_AW-1:0] wl_waddr, wl_raddr;
  logic [CHAR_W-1:0]  pw_wdata, pw_rdata, ls_wdata, ls_rdata;
  logic [LEN_W-1:0]   wl_wdata, wl_rdata;

  // Divider ports.
  logic               div_start, div_done;
  logic [LEN_W-1:0]   div_dividend, div_q;
  logic [CNT_W-1:0]   div_divisor, div_rem;

  logic [LEN_W-1:0]   w;
  logic [LEN_W-1:0]   plen_c;
  logic [LEN_W-1:0]   plen_new;
  logic [LEN_W:0]     need;
  logic               slot_free;
  logic               at_last;
  logic               over;

  tlj_ram #(.DEPTH(MAX_LINE), .WIDTH(CHAR_W)) u_partial (
    .clk(clk), .wr_en(pw_we), .wr_addr(pw_waddr), .wr_data(pw_wdata),
    .rd_en(pw_re), .rd_addr(pw_raddr), .rd_data(pw_rdata)
  );

  tlj_ram #(.DEPTH(MAX_LINE), .WIDTH(CHAR_W)) u_line (
    .clk(clk), .wr_en(ls_we), .wr_addr(ls_waddr), .wr_data(ls_wdata),
    .rd_en(ls_re), .rd_addr(ls_raddr), .rd_data(ls_rdata)
  );

  tlj_ram #(.DEPTH(MAX_WORDS), .WIDTH(LEN_W)) u_wlen (
    .clk(clk), .wr_en(wl_we), .wr_addr(wl_waddr), .wr_data(wl_wdata),
    .rd_en(wl_re), .rd_addr(wl_raddr), .rd_data(wl_rdata)
  );

  tlj_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dividend), .divisor(div_divisor),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign w         = eff_width(width_r);
  assign plen_c    = (plen_r > w) ? w : plen_r;
  assign slot_free = !ov_r || !out_stall;
  assign at_last   = ((LEN_W'(pos_r) + LEN_W'(1)) == w);
  assign over      = chars_r > w;

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = ov_r;
  assign out_char_out       = och_r;
  assign out_line_last      = olast_r;
  assign out_word_truncated = otr_r;

  // Main sequencer: append, copy a finished word, and emit lines.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    width_nxt   = width_r;
    n_nxt       = n_r;
    chars_nxt   = chars_r;
    letters_nxt = letters_r;
    trunc_nxt   = trunc_r;
    plen_nxt    = plen_r;
    pcut_nxt    = pcut_r;
    held_nxt    = held_r;
    emitted_nxt = emitted_r;
    c_nxt       = c_r;
    we_nxt      = we_r;
    te_nxt      = te_r;
    ci_nxt      = ci_r;
    wi_nxt      = wi_r;
    src_nxt     = src_r;
    pos_nxt     = pos_r;
    gap_nxt     = gap_r;
    wrem_nxt    = wrem_r;
    base_nxt    = base_r;
    extra_nxt   = extra_r;
    flag_nxt    = flag_r;
    ov_nxt      = ov_r && out_stall;
    och_nxt     = och_r;
    olast_nxt   = olast_r;
    otr_nxt     = otr_r;

    pw_we    = 1'b0;
    pw_waddr = plen_r[LINE_AW-1:0];
    pw_wdata = c_r;
    pw_re    = 1'b0;
    pw_raddr = ci_r;
    ls_we    = 1'b0;
    ls_waddr = LINE_AW'(letters_r + LEN_W'(ci_r));
    ls_wdata = pw_rdata;
    ls_re    = 1'b0;
    ls_raddr = src_r;
    wl_we    = 1'b0;
    wl_waddr = n_r[WORD_AW-1:0];
    wl_wdata = plen_c;
    wl_re    = 1'b0;
    wl_raddr = wi_r;

    div_start    = 1'b0;
    div_dividend = w - letters_r;
    div_divisor  = n_r - CNT_W'(1);

    plen_new = (plen_r < w) ? plen_r + LEN_W'(1) : plen_r;
    need     = {1'b0, chars_r} + (LEN_W+1)'(1) + {1'b0, plen_new};

    if (cfg_valid) width_nxt = cfg_line_width;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt       = in_char_in;
          we_nxt      = in_word_end;
          te_nxt      = in_text_end;
          emitted_nxt = held_r;
          if (held_r) begin
            held_nxt  = 1'b0;
            ret_nxt   = S_APPEND;
            state_nxt = E_START;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      // Add the character to the word being received, then check for overflow.
      S_APPEND: begin
        if (plen_r < w) begin
          pw_we = 1'b1;
          plen_nxt = plen_new;
        end else begin
          pcut_nxt = 1'b1;
        end
        if (n_r != '0 && (need > (LEN_W+1)'(w) || n_r >= CNT_W'(MAX_WORDS))) begin
          emitted_nxt = 1'b1;
          ret_nxt     = S_WORD;
          state_nxt   = E_START;
        end else begin
          state_nxt = S_WORD;
        end
      end
      S_WORD: begin
        ci_nxt    = '0;
        state_nxt = (we_r || te_r) ? S_CPRD : S_IDLE;
      end
      // Copy the finished word into the line store, reading and then writing each letter.
      S_CPRD: begin
        pw_re     = 1'b1;
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        ls_we = 1'b1;
        if ((LEN_W'(ci_r) + LEN_W'(1)) < plen_c) begin
          ci_nxt    = ci_r + LINE_AW'(1);
          state_nxt = S_CPRD;
        end else begin
          state_nxt = S_CPFIN;
        end
      end
      S_CPFIN: begin
        wl_we       = 1'b1;
        chars_nxt   = chars_r + plen_c + ((n_r != '0) ? LEN_W'(1) : LEN_W'(0));
        letters_nxt = letters_r + plen_c;
        n_nxt       = n_r + CNT_W'(1);
        trunc_nxt   = trunc_r || pcut_r || (plen_r > w);
        pcut_nxt    = 1'b0;
        plen_nxt    = '0;
        if (te_r) begin
          if (emitted_r) begin
            held_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ret_nxt   = S_IDLE;
            state_nxt = E_START;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Line emission setup: gaps even to within one space unless the words overflow.
      E_START: begin
        wi_nxt   = '0;
        src_nxt  = '0;
        pos_nxt  = '0;
        flag_nxt = trunc_r || over;
        base_nxt  = LEN_W'(1);
        extra_nxt = '0;
        if (n_r == '0) begin
          state_nxt = ret_r;
        end else if (!over && n_r > CNT_W'(1)) begin
          div_start = 1'b1;
          state_nxt = E_DIV;
        end else begin
          state_nxt = E_LEN;
        end
      end
      E_DIV: begin
        if (div_done) begin
          base_nxt  = div_q;
          extra_nxt = div_rem;
          state_nxt = E_LEN;
        end
      end
      E_LEN: begin
        wl_re     = 1'b1;
        state_nxt = E_LENW;
      end
      E_LENW: begin
        wrem_nxt = wl_rdata;
        if (wi_r == '0) begin
          state_nxt = E_RD;
        end else begin
          gap_nxt = base_r +
                    ((CNT_W'(wi_r - WORD_AW'(1)) < extra_r) ? LEN_W'(1) : LEN_W'(0));
          state_nxt = E_GAP;
        end
      end
      // Gap spaces before a word.
      E_GAP: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = SPACE_CHAR;
          olast_nxt = at_last;
          otr_nxt   = flag_r;
          pos_nxt   = pos_r + LINE_AW'(1);
          gap_nxt   = gap_r - LEN_W'(1);
          if (at_last) state_nxt = ret_r;
          else if (gap_r == LEN_W'(1)) state_nxt = E_RD;
        end
      end
      E_RD: begin
        ls_re     = 1'b1;
        state_nxt = E_CH;
      end
      // One letter of the current word.
      E_CH: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = ls_rdata;
          olast_nxt = at_last;
          otr_nxt   = flag_r;
          pos_nxt   = pos_r + LINE_AW'(1);
          src_nxt   = src_r + LINE_AW'(1);
          wrem_nxt  = wrem_r - LEN_W'(1);
          if (at_last) begin
            state_nxt = ret_r;
          end else if (wrem_r != LEN_W'(1)) begin
            state_nxt = E_RD;
          end else if ((CNT_W'(wi_r) + CNT_W'(1)) < n_r) begin
            wi_nxt    = wi_r + WORD_AW'(1);
            state_nxt = E_LEN;
          end else begin
            state_nxt = E_PAD;
          end
        end
      end
      // Right padding after the last word.
      E_PAD: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = SPACE_CHAR;
          olast_nxt = at_last;
          otr_nxt   = flag_r;
          pos_nxt   = pos_r + LINE_AW'(1);
          if (at_last) state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A finished or empty line clears the pending-line bookkeeping.
    if (state_r != state_nxt && state_nxt == ret_r &&
        (state_r == E_START || state_r == E_GAP || state_r == E_CH ||
         state_r == E_PAD)) begin
      n_nxt       = '0;
      chars_nxt   = '0;
      letters_nxt = '0;
      trunc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      width_r   <= WIDTH_RESET;
      n_r       <= '0;
      chars_r   <= '0;
      letters_r <= '0;
      trunc_r   <= 1'b0;
      plen_r    <= '0;
      pcut_r    <= 1'b0;
      held_r    <= 1'b0;
      emitted_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      width_r   <= width_nxt;
      n_r       <= n_nxt;
      chars_r   <= chars_nxt;
      letters_r <= letters_nxt;
      trunc_r   <= trunc_nxt;
      plen_r    <= plen_nxt;
      pcut_r    <= pcut_nxt;
      held_r    <= held_nxt;
      emitted_r <= emitted_nxt;
      ov_r      <= ov_nxt;
    end
    c_r     <= c_nxt;
    we_r    <= we_nxt;
    te_r    <= te_nxt;
    ci_r    <= ci_nxt;
    wi_r    <= wi_nxt;
    src_r   <= src_nxt;
    pos_r   <= pos_nxt;
    gap_r   <= gap_nxt;
    wrem_r  <= wrem_nxt;
    base_r  <= base_nxt;
    extra_r <= extra_nxt;
    flag_r  <= flag_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
    otr_r   <= otr_nxt;
  end

endmodule
